[design/bdq_pkg.sv]
// Package for the bounded double-ended queue: sizes, payload structs, operation
// and status codes, and ring-pointer helpers. No dependencies.
`default_nettype none

package bdq_pkg;

  // Entry-memory depth with its pointer and count widths, and the other sizes.
  localparam int DEPTH     = 16;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int WORD_W    = 32;
  localparam int CAP_W     = 5;
  localparam int OCC_W     = 5;
  localparam int CAP_RESET = 16;
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    FN_PUSH_FRONT,
    FN_PUSH_BACK,
    FN_POP_FRONT,
    FN_POP_BACK
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_FULL,
    ST_EMPTY
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    func_t                     func;
    logic signed [WORD_W-1:0]  push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  pop_value;
    status_t                   status;
    logic        [OCC_W-1:0]   occupancy;
  } out_item_t;

  // Tells the output stage to load a result, and whether the popped word
  // comes from the memory read port.
  typedef struct packed {
    logic                load;
    logic                from_ram;
    status_t             status;
    logic [OCC_W-1:0]    occupancy;
  } res_load_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

`default_nettype wire

[design/bdq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a registered
// read. No dependencies.
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/bdq_ctrl.sv]
// Ring-buffer control for the deque: head and tail pointers, word count,
// memory port drive and result sequencing. Depends on bdq_pkg.
`default_nettype none

module bdq_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire bdq_pkg::in_item_t          in_data,
  input  wire logic [bdq_pkg::CAP_W-1:0]  capacity,
  input  wire logic                       out_free,
  output logic                            ram_we,
  output logic [bdq_pkg::PTR_W-1:0]       ram_waddr,
  output logic [bdq_pkg::WORD_W-1:0]      ram_wdata,
  output logic                            ram_re,
  output logic [bdq_pkg::PTR_W-1:0]       ram_raddr,
  output bdq_pkg::res_load_t              res
);
  import bdq_pkg::*;

  state_t           state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic             full, empty, accept;

  // Head points at the front word, tail at the slot after the back word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  assign full  = (CMP_W'(count) >= CMP_W'(capacity)) || (count >= CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign ram_wdata = in_data.push_value;

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    in_ready      = 1'b0;
    accept        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = head;
    ram_re        = 1'b0;
    ram_raddr     = head;
    res.load      = 1'b0;
    res.from_ram  = 1'b0;
    res.status    = ST_DONE;
    res.occupancy = OCC_W'(count);

    unique case (state)
      S_IDLE: begin
        in_ready = out_free;
        accept   = in_valid && out_free;
        if (accept) begin
          unique case (in_data.func)
            FN_PUSH_FRONT: begin
              res.load = 1'b1;
              if (full) begin
                res.status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_dec(head);
                head_next  = ptr_dec(head);
                count_next = count + 1'b1;
              end
            end
            FN_PUSH_BACK: begin
              res.load = 1'b1;
              if (full) begin
                res.status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = tail;
                tail_next  = ptr_inc(tail);
                count_next = count + 1'b1;
              end
            end
            FN_POP_FRONT: begin
              if (empty) begin
                res.load   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = head;
                head_next  = ptr_inc(head);
                count_next = count - 1'b1;
                state_next = S_READ;
              end
            end
            FN_POP_BACK: begin
              if (empty) begin
                res.load   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = ptr_dec(tail);
                tail_next  = ptr_dec(tail);
                count_next = count - 1'b1;
                state_next = S_READ;
              end
            end
            default: ;
          endcase
          res.occupancy = OCC_W'(count_next);
        end
      end
      S_READ: begin
        // Read data is valid this cycle; the count already reflects the pop.
        res.load     = 1'b1;
        res.from_ram = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[design/bounded_deque.sv]
// Top level of the bounded double-ended queue: capacity register, output
// register and wiring of bdq_ctrl and bdq_ram. Depends on bdq_pkg.
//
//   channel | signals                      | payload
//   --------+------------------------------+--------------------------------
//   cfg     | cfg_valid, cfg_ready         | cfg_data: capacity (5 bits)
//   in      | in_valid, in_ready           | in_data: func, push_value
//   out     | out_valid, out_ready         | out_data: pop_value, status,
//           |                              |           occupancy
//
// For a push, and for any rejected operation, the result is registered at the
// edge of the input transfer; a successful push also writes its word to the
// entry memory in that cycle. A successful pop first reads the entry memory,
// whose read port is registered, then loads the result from that read data.
// Reset empties the queue and sets the capacity to 16; the memory itself is not
// cleared, since only entries that were written are ever read.
// A new item is taken while no pop awaits read data and the output register is
// empty or transferring its result; a stalled output holds off the input.
`default_nettype none

module bounded_deque (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [bdq_pkg::CAP_W-1:0]  cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire bdq_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output bdq_pkg::out_item_t              out_data
);
  import bdq_pkg::*;

  logic [CAP_W-1:0]  capacity;
  logic              out_free;
  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  res_load_t         res;

  // The capacity register takes a write in any cycle; the user must write it only
  // while the queue is idle, as the block itself does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // The output register is free when empty or when its result transfers now.
  assign out_free = !out_valid || out_ready;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .capacity  (capacity),
    .out_free  (out_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  bdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register. A load only happens when the register is free, so a
  // waiting result is never overwritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_data.pop_value <= res.from_ram ? ram_rdata : '0;
      out_data.status    <= res.status;
      out_data.occupancy <= res.occupancy;
    end
  end

endmodule

`default_nettype wire

[verif/bounded_deque_tb.sv]
// Self-checking testbench for bounded_deque: directed and random deque operations
// with random idling on both channels, checked against a queue-based predictor.
// Depends on bdq_pkg and the bounded_deque RTL.
`default_nettype none

module bounded_deque_tb;
  import bdq_pkg::*;

  // Clock, reset and the three channels. Every input starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;

  // Predictor state: the stored words, front at index 0, and the capacity
  // register as the block holds it.
  logic signed [WORD_W-1:0] stored_words[$];
  logic [CAP_W-1:0]         capacity_reg = CAP_W'(CAP_RESET);

  // Results predicted for accepted operations, oldest first.
  out_item_t results_due[$];

  int error_count = 0;

  // When set, neither side idles. Used for a long uninterrupted stretch.
  bit steady = 1'b0;

  // Number of cycles the receiver still has to hold off. The receiver
  // process counts it down on its own.
  int hold_left = 0;

  // Words that exercise the sign bit and alternating bit patterns.
  logic [WORD_W-1:0] corner_words [4] = '{32'h8000_0000, 32'h7fff_ffff,
                                          32'h5555_5555, 32'haaaa_aaaa};

  bounded_deque dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one operation to the predicted deque and returns the result the
  // block must produce for it. The limit is the capacity saturated at the
  // built depth, so a capacity of zero rejects every push.
  function automatic out_item_t predict_deque_op(input in_item_t op);
    out_item_t   res;
    int unsigned limit;
    res = '0;
    res.status = ST_DONE;
    limit = (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
    case (op.func)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (stored_words.size() >= limit) begin
          res.status = ST_FULL;
        end else if (op.func == FN_PUSH_FRONT) begin
          stored_words.push_front(op.push_value);
        end else begin
          stored_words.push_back(op.push_value);
        end
      end
      default: begin
        if (stored_words.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (op.func == FN_POP_FRONT) begin
          res.pop_value = stored_words.pop_front();
        end else begin
          res.pop_value = stored_words.pop_back();
        end
      end
    endcase
    res.occupancy = OCC_W'(stored_words.size());
    return res;
  endfunction

  // Offers one operation, possibly after a short random gap, and waits for
  // its transfer. Valid is left high afterwards so that back-to-back
  // operations keep it asserted; a gap in the next call or a drain lowers it.
  task automatic send_op(input func_t fn, input logic [WORD_W-1:0] word);
    in_item_t op;
    op.func = fn;
    op.push_value = word;
    if (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    results_due.push_back(predict_deque_op(op));
  endtask

  // One random operation. push_pct sets how often it is a push, which
  // steers the deque toward full or toward empty.
  task automatic send_random_op(input int push_pct);
    func_t             fn;
    logic [WORD_W-1:0] word;
    if ($urandom_range(99) < push_pct) begin
      fn = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
    end else begin
      fn = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
    end
    word = ($urandom_range(7) == 0) ? corner_words[$urandom_range(3)] : $urandom;
    send_op(fn, word);
  endtask

  // Stops offering operations and waits until every predicted result has
  // come back, then lets the block settle before anything else is done.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the capacity register, only once the block is idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    capacity_reg = cap;
    cfg_valid <= 1'b0;
  endtask

  // Pops on an empty deque right after reset, from both ends.
  task automatic test_empty_pops();
    send_op(FN_POP_FRONT, 32'hffff_ffff);
    send_op(FN_POP_BACK, 32'h0000_0000);
  endtask

  // Pushes the extreme words at both ends, then pops them all back out,
  // alternating ends, so every operation moves a corner value.
  task automatic test_word_extremes();
    send_op(FN_PUSH_BACK, 32'h8000_0000);
    send_op(FN_PUSH_FRONT, 32'h7fff_ffff);
    send_op(FN_PUSH_BACK, 32'hffff_ffff);
    send_op(FN_PUSH_FRONT, 32'h0000_0000);
    send_op(FN_PUSH_BACK, 32'h5555_5555);
    send_op(FN_PUSH_FRONT, 32'haaaa_aaaa);
    send_op(FN_POP_FRONT, 32'h0);
    send_op(FN_POP_BACK, 32'h0);
    send_op(FN_POP_FRONT, 32'h0);
    send_op(FN_POP_BACK, 32'h0);
    send_op(FN_POP_FRONT, 32'h0);
    send_op(FN_POP_BACK, 32'h0);
  endtask

  // A capacity of zero rejects every push as full.
  task automatic test_capacity_zero();
    set_capacity('0);
    send_op(FN_PUSH_FRONT, 32'h1234_5678);
    send_op(FN_PUSH_BACK, 32'h8765_4321);
  endtask

  // Fills a deque of capacity three, then lowers the capacity below the
  // count. The stored words stay and pushes are refused until pops bring
  // the count under the new limit.
  task automatic test_capacity_lowered();
    set_capacity(CAP_W'(3));
    send_op(FN_PUSH_BACK, 32'h0000_0011);
    send_op(FN_PUSH_BACK, 32'h0000_0022);
    send_op(FN_PUSH_FRONT, 32'h0000_0033);
    send_op(FN_PUSH_FRONT, 32'h0000_0044);
    set_capacity(CAP_W'(1));
    send_op(FN_PUSH_FRONT, 32'h0000_0055);
    send_op(FN_POP_FRONT, 32'h0);
    send_op(FN_POP_BACK, 32'h0);
    send_op(FN_PUSH_BACK, 32'h0000_0066);
    send_op(FN_POP_FRONT, 32'h0);
    send_op(FN_PUSH_BACK, 32'h0000_0077);
  endtask

  // The receiver holds off for a long stretch while operations keep
  // coming, so the output register fills and the input stalls. The sender
  // then pauses until every result is back.
  task automatic test_backpressure();
    set_capacity(CAP_W'(CAP_RESET));
    hold_left = 150;
    repeat (40) send_random_op(60);
    drain_results();
  endtask

  // Phases of random operations under different capacities, including
  // both extremes of the register and values above the built depth. Each
  // phase leans toward pushes first and pops later so the deque fills up
  // and empties again.
  task automatic test_random_phases();
    logic [CAP_W-1:0] caps [8];
    caps = '{CAP_W'(16), CAP_W'(31), CAP_W'(0), CAP_W'(1), CAP_W'(17), CAP_W'(2),
             CAP_W'($urandom_range(31)), CAP_W'($urandom_range(31))};
    foreach (caps[i]) begin
      set_capacity(caps[i]);
      repeat (55) send_random_op(75);
      repeat (55) send_random_op(30);
    end
  endtask

  // A long run with no idling on either side, one op per cycle except during pop reads.
  task automatic test_steady_stream();
    set_capacity(CAP_W'(16));
    steady = 1'b1;
    repeat (150) send_random_op(50);
    steady = 1'b0;
    drain_results();
  endtask

  // Receiver: idles at random unless in a steady stretch, and holds off
  // completely while a long hold is counting down.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  // Checks each result transfer against the oldest prediction, field by
  // field. Values are sampled as they stood before the edge.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: pop_value %0d, status %0d, occupancy %0d",
               out_data.pop_value, out_data.status, out_data.occupancy);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (out_data.pop_value !== want.pop_value) begin
          $error("pop_value: expected %0d, got %0d", want.pop_value,
                 out_data.pop_value);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy,
                 out_data.occupancy);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset once, run each test in turn, then wait for the
  // last results and report.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pops();
    test_word_extremes();
    test_capacity_zero();
    test_capacity_lowered();
    test_backpressure();
    test_random_phases();
    test_steady_stream();
    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
